// ----- rtl/ests_pkg.sv -----
`default_nettype none

package ests_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 24;          // unsigned Q8.16
  localparam int RATE_W      = 16;          // unsigned Q0.16
  localparam int DELTA_W     = 9;
  localparam int PHASE_W     = 2;
  localparam int OUT_W       = 8;
  localparam int MAG_W       = 27;          // largest goal step: 256 * 4 in Q8.16
  localparam int SUM_W       = 29;          // signed goal +/- step
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef logic [VAL_W-1:0]          fx_t;
  typedef logic [RATE_W-1:0]         rate_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [OUT_W-1:0]          byte_t;
  typedef logic [1:0]                step_kind_t;

  // Request kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_ENCODER = 1'b1;

  // Phases
  localparam phase_t PHASE_ARRIVAL = 2'd0;
  localparam phase_t PHASE_DEEP    = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING_RATE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SNAP_THRESHOLD = 1'b1;

  localparam rate_t RATE_RESET = 16'd3604;
  localparam rate_t SNAP_RESET = 16'd2621;

  // Goal step scaling per detent
  localparam step_kind_t STEP_X4   = 2'd0;
  localparam step_kind_t STEP_X3   = 2'd1;
  localparam step_kind_t STEP_X4_3 = 2'd2;

  localparam fx_t SPEED_START_FX     = fx_t'(120 << FRAC_BITS);
  localparam fx_t INTENSITY_START_FX = fx_t'(220 << FRAC_BITS);
  localparam fx_t HUE_START_FX       = fx_t'(160 << FRAC_BITS);
  localparam fx_t SAT_START_FX       = fx_t'(150 << FRAC_BITS);

  localparam fx_t SPEED_LO_FX     = fx_t'(48 << FRAC_BITS);
  localparam fx_t SPEED_HI_FX     = fx_t'(200 << FRAC_BITS);
  localparam fx_t INTENSITY_LO_FX = fx_t'(160 << FRAC_BITS);
  localparam fx_t INTENSITY_HI_FX = fx_t'(255 << FRAC_BITS);
  localparam fx_t SAT_LO_FX       = fx_t'(80 << FRAC_BITS);
  localparam fx_t SAT_HI_FX       = fx_t'(220 << FRAC_BITS);
  localparam fx_t HUE_LO_FX       = fx_t'(140 << FRAC_BITS);
  localparam fx_t HUE_HI_FX       = fx_t'(175 << FRAC_BITS);

  typedef struct packed {
    step_kind_t kind;
    fx_t        lo;
    fx_t        hi;
  } goal_rule_t;

  typedef struct packed {
    logic   req_type;
    delta_t first_knob_delta;
    delta_t second_knob_delta;
    phase_t mode_phase;
  } item_t;

  // Round half up to an integer, saturate at 255.
  function automatic byte_t round8(input fx_t v);
    logic [VAL_W:0] s;
    s = {1'b0, v} + (VAL_W+1)'(1 << (FRAC_BITS - 1));
    if (s[VAL_W]) begin
      round8 = '1;
    end else begin
      round8 = s[FRAC_BITS+OUT_W-1:FRAC_BITS];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ests_goal_unit.sv -----
`default_nettype none

module ests_goal_unit (
  input  wire logic                  en,
  input  wire ests_pkg::goal_rule_t  rule,
  input  wire ests_pkg::fx_t         goal,
  input  wire ests_pkg::delta_t      delta,
  output      ests_pkg::fx_t         goal_nxt
);

  logic [ests_pkg::DELTA_W-1:0]   abs_d;
  logic [17:0]                    third_prod;
  logic [ests_pkg::DELTA_W-1:0]   third;
  logic [ests_pkg::MAG_W-1:0]     mag;
  logic signed [ests_pkg::SUM_W-1:0] g_ext;
  logic signed [ests_pkg::SUM_W-1:0] m_ext;
  logic signed [ests_pkg::SUM_W-1:0] lo_ext;
  logic signed [ests_pkg::SUM_W-1:0] hi_ext;
  logic signed [ests_pkg::SUM_W-1:0] sum;

  // Magnitude of the detent count; -256 folds to 256 as unsigned.
  assign abs_d = delta[ests_pkg::DELTA_W-1] ? (~delta + 1'b1) : delta;

  // floor((|d| + 1) / 3) by reciprocal 171/512, exact below 512
  assign third_prod = 18'(({1'b0, abs_d} + 10'd1) * 18'd171);
  assign third      = third_prod[17:9];

  // 4/3 step: (|d| * 2^18 + 1) / 3 = |d| * 87381 + floor((|d| + 1) / 3)
  always_comb begin
    case (rule.kind)
      ests_pkg::STEP_X4:   mag = {abs_d, 18'b0};
      ests_pkg::STEP_X3:   mag = 27'({abs_d, 16'b0}) + 27'({abs_d, 17'b0});
      ests_pkg::STEP_X4_3: mag = 27'(abs_d * 27'd87381) + 27'(third);
      default:             mag = '0;
    endcase
  end

  assign g_ext  = {5'b0, goal};
  assign m_ext  = {2'b0, mag};
  assign lo_ext = {5'b0, rule.lo};
  assign hi_ext = {5'b0, rule.hi};
  assign sum    = delta[ests_pkg::DELTA_W-1] ? (g_ext - m_ext) : (g_ext + m_ext);

  always_comb begin
    if (!en || (delta == '0)) begin
      goal_nxt = goal;
    end else if (sum < lo_ext) begin
      goal_nxt = rule.lo;
    end else if (sum > hi_ext) begin
      goal_nxt = rule.hi;
    end else begin
      goal_nxt = sum[ests_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ests_slew_unit.sv -----
`default_nettype none

module ests_slew_unit (
  input  wire ests_pkg::fx_t    now,
  input  wire ests_pkg::fx_t    goal,
  input  wire ests_pkg::rate_t  rate,
  input  wire ests_pkg::rate_t  snap,
  output      ests_pkg::fx_t    now_nxt
);

  localparam int PROD_W = ests_pkg::VAL_W + ests_pkg::RATE_W;

  logic signed [ests_pkg::VAL_W:0] gap;
  logic [ests_pkg::VAL_W-1:0]      mag;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W:0]                 prod_rnd;
  logic [ests_pkg::VAL_W-1:0]      step;

  assign gap = {1'b0, goal} - {1'b0, now};
  assign mag = gap[ests_pkg::VAL_W] ? ests_pkg::VAL_W'(-gap) : gap[ests_pkg::VAL_W-1:0];

  assign prod     = mag * PROD_W'(rate);
  assign prod_rnd = {1'b0, prod} + (PROD_W+1)'(1 << 15);
  // The rounded step never exceeds the gap, so the low bits above the point suffice.
  assign step     = prod_rnd[16 +: ests_pkg::VAL_W];

  always_comb begin
    if (mag < ests_pkg::VAL_W'(snap)) begin
      now_nxt = goal;
    end else if (gap[ests_pkg::VAL_W]) begin
      now_nxt = now - step;
    end else begin
      now_nxt = now + step;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/encoder_target_slew_smoother.sv -----
`default_nettype none

// Channel   Direction  tdata (lowest bit up)                        tuser
// in_       slave      first_knob_delta[8:0] second_knob_delta[17:9]  req_type
//                      mode_phase[19:18] zero[23:20]
// out_      master     speed[7:0] intensity[15:8] hue[23:16]       none
//                      saturation[31:24]
// cfg_      write      index 0 smoothing_rate, 1 snap_threshold     none
//
// One item per cycle sustained while out_tready holds high. The input register takes
// an item at its transfer; the goal/slew logic (24x16 slew multipliers set the path)
// then loads the result register when it is empty or draining, which sets out_tvalid.
// rst_n (synchronous) restores start values, empties both stages and reloads
// the register defaults. A stalled result register stops the input stage only
// when that stage also holds an item.

module encoder_target_slew_smoother (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // first_knob_delta, second_knob_delta, mode_phase, zero pad
  input  wire logic [ests_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  wire logic                              in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // speed_out, intensity_out, hue_out, saturation_out
  output      logic [ests_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [ests_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [ests_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam ests_pkg::goal_rule_t SPEED_RULE =
    '{kind: ests_pkg::STEP_X4, lo: ests_pkg::SPEED_LO_FX, hi: ests_pkg::SPEED_HI_FX};
  localparam ests_pkg::goal_rule_t INTENSITY_RULE =
    '{kind: ests_pkg::STEP_X4, lo: ests_pkg::INTENSITY_LO_FX, hi: ests_pkg::INTENSITY_HI_FX};
  localparam ests_pkg::goal_rule_t SAT_RULE =
    '{kind: ests_pkg::STEP_X3, lo: ests_pkg::SAT_LO_FX, hi: ests_pkg::SAT_HI_FX};
  localparam ests_pkg::goal_rule_t HUE_RULE =
    '{kind: ests_pkg::STEP_X4_3, lo: ests_pkg::HUE_LO_FX, hi: ests_pkg::HUE_HI_FX};

  // Configuration
  ests_pkg::rate_t rate_r;
  ests_pkg::rate_t snap_r;

  // Input stage
  logic             st_valid_r;
  ests_pkg::item_t  st_item_r;
  logic             advance;
  logic             fire;

  // Smoothed values and goals
  ests_pkg::fx_t speed_now_r, intensity_now_r, hue_now_r, sat_now_r;
  ests_pkg::fx_t speed_goal_r, intensity_goal_r, hue_goal_r, sat_goal_r;
  ests_pkg::fx_t speed_goal_nxt, intensity_goal_nxt, hue_goal_nxt, sat_goal_nxt;
  ests_pkg::fx_t speed_slew, intensity_slew, hue_slew, sat_slew;
  ests_pkg::fx_t speed_now_nxt, intensity_now_nxt, hue_now_nxt, sat_now_nxt;

  logic is_tick;
  logic arrival_en;
  logic deep_en;

  // Result register
  logic                               out_valid_r;
  logic [ests_pkg::OUT_TDATA_W-1:0]   out_data_r;

  // Advance the input stage when the result register is empty or draining.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = st_valid_r && advance;
  assign in_tready = !st_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= ests_pkg::RATE_RESET;
      snap_r <= ests_pkg::SNAP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ests_pkg::CFG_SMOOTHING_RATE: rate_r <= cfg_wdata;
        ests_pkg::CFG_SNAP_THRESHOLD: snap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture an item on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_tready) begin
      st_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      st_item_r.req_type          <= in_tuser;
      st_item_r.first_knob_delta  <= in_tdata[8:0];
      st_item_r.second_knob_delta <= in_tdata[17:9];
      st_item_r.mode_phase        <= in_tdata[19:18];
    end
  end

  assign is_tick    = (st_item_r.req_type == ests_pkg::REQ_TICK);
  assign arrival_en = !is_tick && (st_item_r.mode_phase == ests_pkg::PHASE_ARRIVAL);
  assign deep_en    = !is_tick && (st_item_r.mode_phase == ests_pkg::PHASE_DEEP);

  // Goal updates: arrival moves speed/intensity, deep moves saturation/hue.
  ests_goal_unit u_speed_goal (
    .en(arrival_en), .rule(SPEED_RULE), .goal(speed_goal_r),
    .delta(st_item_r.first_knob_delta), .goal_nxt(speed_goal_nxt));

  ests_goal_unit u_intensity_goal (
    .en(arrival_en), .rule(INTENSITY_RULE), .goal(intensity_goal_r),
    .delta(st_item_r.second_knob_delta), .goal_nxt(intensity_goal_nxt));

  ests_goal_unit u_sat_goal (
    .en(deep_en), .rule(SAT_RULE), .goal(sat_goal_r),
    .delta(st_item_r.first_knob_delta), .goal_nxt(sat_goal_nxt));

  ests_goal_unit u_hue_goal (
    .en(deep_en), .rule(HUE_RULE), .goal(hue_goal_r),
    .delta(st_item_r.second_knob_delta), .goal_nxt(hue_goal_nxt));

  // Slew every value toward its goal; only a tick takes the result.
  ests_slew_unit u_speed_slew (
    .now(speed_now_r), .goal(speed_goal_r), .rate(rate_r), .snap(snap_r),
    .now_nxt(speed_slew));

  ests_slew_unit u_intensity_slew (
    .now(intensity_now_r), .goal(intensity_goal_r), .rate(rate_r), .snap(snap_r),
    .now_nxt(intensity_slew));

  ests_slew_unit u_hue_slew (
    .now(hue_now_r), .goal(hue_goal_r), .rate(rate_r), .snap(snap_r),
    .now_nxt(hue_slew));

  ests_slew_unit u_sat_slew (
    .now(sat_now_r), .goal(sat_goal_r), .rate(rate_r), .snap(snap_r),
    .now_nxt(sat_slew));

  assign speed_now_nxt     = is_tick ? speed_slew     : speed_now_r;
  assign intensity_now_nxt = is_tick ? intensity_slew : intensity_now_r;
  assign hue_now_nxt       = is_tick ? hue_slew       : hue_now_r;
  assign sat_now_nxt       = is_tick ? sat_slew       : sat_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_now_r      <= ests_pkg::SPEED_START_FX;
      intensity_now_r  <= ests_pkg::INTENSITY_START_FX;
      hue_now_r        <= ests_pkg::HUE_START_FX;
      sat_now_r        <= ests_pkg::SAT_START_FX;
      speed_goal_r     <= ests_pkg::SPEED_START_FX;
      intensity_goal_r <= ests_pkg::INTENSITY_START_FX;
      hue_goal_r       <= ests_pkg::HUE_START_FX;
      sat_goal_r       <= ests_pkg::SAT_START_FX;
    end else if (fire) begin
      speed_now_r      <= speed_now_nxt;
      intensity_now_r  <= intensity_now_nxt;
      hue_now_r        <= hue_now_nxt;
      sat_now_r        <= sat_now_nxt;
      speed_goal_r     <= speed_goal_nxt;
      intensity_goal_r <= intensity_goal_nxt;
      hue_goal_r       <= hue_goal_nxt;
      sat_goal_r       <= sat_goal_nxt;
    end
  end

  // Result register: hold while stalled; once taken, reload from the input stage or drop valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= st_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {ests_pkg::round8(sat_now_nxt), ests_pkg::round8(hue_now_nxt),
                     ests_pkg::round8(intensity_now_nxt), ests_pkg::round8(speed_now_nxt)};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ests_checker.sv -----
`default_nettype none

module ests_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ests_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A fresh result follows an input transfer carried through the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transfer");

  // Values stay inside the clamped goal ranges (speed and hue).
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] >= 8'd48) && (out_tdata[7:0] <= 8'd200) &&
                   (out_tdata[23:16] >= 8'd140) && (out_tdata[23:16] <= 8'd175))
    else $error("smoothed value outside its range");

endmodule

bind encoder_target_slew_smoother ests_checker u_ests_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

`default_nettype wire
